// ===== rtl/c2sd_pkg.sv =====
package c2sd_pkg;

  localparam int AngleIterations = 16;
  localparam int AccW = 28;
  localparam int CordW = 40;
  localparam int SqW = 50;
  localparam int RootW = 25;
  localparam int DotW = 47;
  localparam int QW = 22;
  localparam logic [AccW-1:0] HalfTurn = AccW'(16777216);

  function automatic logic [AccW-1:0] atan_entry(input int i);
    logic [AccW-1:0] t;
    case (i)
      0: t = AccW'(4194304);
      1: t = AccW'(2476042);
      2: t = AccW'(1308273);
      3: t = AccW'(664100);
      4: t = AccW'(333339);
      5: t = AccW'(166832);
      6: t = AccW'(83436);
      7: t = AccW'(41721);
      8: t = AccW'(20861);
      9: t = AccW'(10430);
      10: t = AccW'(5215);
      11: t = AccW'(2608);
      12: t = AccW'(1304);
      13: t = AccW'(652);
      14: t = AccW'(326);
      15: t = AccW'(163);
      16: t = AccW'(81);
      17: t = AccW'(41);
      18: t = AccW'(20);
      19: t = AccW'(10);
      20: t = AccW'(5);
      21: t = AccW'(3);
      22: t = AccW'(1);
      23: t = AccW'(1);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/c2sd_cordic_cell.sv =====
module c2sd_cordic_cell (
  input  logic                              clk,
  input  logic                              en,
  input  logic [4:0]                        step_i,
  input  logic signed [c2sd_pkg::CordW-1:0] x_i,
  input  logic signed [c2sd_pkg::CordW-1:0] y_i,
  input  logic signed [c2sd_pkg::AccW-1:0]  a_i,
  output logic signed [c2sd_pkg::CordW-1:0] x_r,
  output logic signed [c2sd_pkg::CordW-1:0] y_r,
  output logic signed [c2sd_pkg::AccW-1:0]  a_r
);
  logic signed [c2sd_pkg::CordW-1:0] x_nxt, y_nxt;
  logic signed [c2sd_pkg::AccW-1:0] a_nxt;
  always_comb begin
    if (!y_i[c2sd_pkg::CordW-1]) begin
      x_nxt = x_i + (y_i >>> step_i);
      y_nxt = y_i - (x_i >>> step_i);
      a_nxt = a_i + $signed(c2sd_pkg::atan_entry(int'(step_i)));
    end else begin
      x_nxt = x_i - (y_i >>> step_i);
      y_nxt = y_i + (x_i >>> step_i);
      a_nxt = a_i - $signed(c2sd_pkg::atan_entry(int'(step_i)));
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      a_r <= a_nxt;
    end
  end
endmodule

// ===== rtl/c2sd_isqrt_cell.sv =====
module c2sd_isqrt_cell (
  input  logic                           clk,
  input  logic                           en,
  input  logic [4:0]                     step_i,
  input  logic [c2sd_pkg::SqW-1:0]       rem_i,
  input  logic [c2sd_pkg::RootW-1:0]     root_i,
  output logic [c2sd_pkg::SqW-1:0]       rem_r,
  output logic [c2sd_pkg::RootW-1:0]     root_r
);
  logic [5:0] sh;
  logic [c2sd_pkg::SqW+1:0] trial;
  logic [c2sd_pkg::SqW+1:0] remw;
  assign sh = 6'(2 * (c2sd_pkg::RootW - 1)) - {step_i, 1'b0};
  always_comb begin
    trial = ({(c2sd_pkg::SqW+2-c2sd_pkg::RootW)'(0), root_i} << (sh + 6'd2))
          | ((c2sd_pkg::SqW+2)'(1) << sh);
    remw = {2'b00, rem_i};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (remw >= trial) begin
        rem_r  <= c2sd_pkg::SqW'(remw - trial);
        root_r <= {root_i[c2sd_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_r  <= rem_i;
        root_r <= {root_i[c2sd_pkg::RootW-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== rtl/c2sd_div_cell.sv =====
module c2sd_div_cell (
  input  logic                          clk,
  input  logic                          en,
  input  logic [4:0]                    step_i,
  input  logic [c2sd_pkg::DotW+c2sd_pkg::RootW-1:0] rem_i,
  input  logic [c2sd_pkg::RootW-1:0]    den_i,
  input  logic [c2sd_pkg::QW-1:0]       q_i,
  output logic [c2sd_pkg::DotW+c2sd_pkg::RootW-1:0] rem_r,
  output logic [c2sd_pkg::QW-1:0]       q_r
);
  localparam int W = c2sd_pkg::DotW + c2sd_pkg::RootW;
  logic [4:0] sh;
  logic [W-1:0] dsh;
  assign sh = 5'(c2sd_pkg::QW - 1) - step_i;
  assign dsh = {(W-c2sd_pkg::RootW)'(0), den_i} << sh;
  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_i >= dsh) begin
        rem_r <= rem_i - dsh;
        q_r   <= {q_i[c2sd_pkg::QW-2:0], 1'b1};
      end else begin
        rem_r <= rem_i;
        q_r   <= {q_i[c2sd_pkg::QW-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== rtl/cartesian_to_spherical_doppler_core.sv =====
// channel  | ports                                   | dir
// in       | in_valid/in_ready, pos_*, vel_*         | input
// out      | out_valid/out_ready, range, angles, rv  | output
// cfg      | cfg_valid/cfg_ready, cfg_three_dimensional | input
// One beat per cycle while the output is not stalled; chained cells: 3 front
// stages, 25 root cells, 16 CORDIC cells per angle, 22 divider cells, 1 output
// stage. The whole chain advances when the output register is free or being
// taken, so in_ready drops only while a full output register is stalled.
// rst_n clears valid bits and sets the 3D mode.
module cartesian_to_spherical_doppler_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_pos_z,
  input  logic signed [19:0] in_vel_x,
  input  logic signed [19:0] in_vel_y,
  input  logic signed [19:0] in_vel_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        out_slant_range,
  output logic signed [15:0] out_azimuth,
  output logic signed [15:0] out_elevation,
  output logic signed [20:0] out_radial_velocity,
  output logic               out_zero_range,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_three_dimensional
);
  localparam int CW = c2sd_pkg::CordW;
  localparam int AW = c2sd_pkg::AccW;
  localparam int SW = c2sd_pkg::SqW;
  localparam int RW = c2sd_pkg::RootW;
  localparam int DW = c2sd_pkg::DotW;
  localparam int QW = c2sd_pkg::QW;
  localparam int NI = c2sd_pkg::AngleIterations;
  localparam int DVW = DW + RW;
  // stage counts: front 3, root RW, elevation NI, div QW
  localparam int L1 = 3 + RW;          // roots ready
  localparam int L2 = L1 + NI;         // elevation ready
  localparam int LT = L2 + QW;         // quotient ready

  logic en;
  logic is3d_r;
  assign cfg_ready = 1'b1;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) is3d_r <= 1'b1;
    else if (cfg_valid) is3d_r <= cfg_three_dimensional;
  end

  // valid chain
  logic [LT-1:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[LT-2:0], in_valid};
  end

  // front: stage0 capture, stage1 products, stage2 sums
  logic signed [23:0] x0_r, y0_r, z0_r;
  logic signed [19:0] vx0_r, vy0_r, vz0_r;
  logic signed [47:0] px1_r, py1_r, pz1_r;
  logic signed [43:0] dx1_r, dy1_r, dz1_r;
  logic [SW-1:0] hsq2_r, rsq2_r;
  logic signed [DW-1:0] dot2_r;
  logic signed [23:0] x1_r, y1_r, z1_r, x2_r, y2_r, z2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= in_pos_x; y0_r <= in_pos_y;
      z0_r <= is3d_r ? in_pos_z : '0;
      vx0_r <= in_vel_x; vy0_r <= in_vel_y;
      vz0_r <= is3d_r ? in_vel_z : '0;
      px1_r <= x0_r * x0_r; py1_r <= y0_r * y0_r; pz1_r <= z0_r * z0_r;
      dx1_r <= x0_r * vx0_r; dy1_r <= y0_r * vy0_r; dz1_r <= z0_r * vz0_r;
      x1_r <= x0_r; y1_r <= y0_r; z1_r <= z0_r;
      hsq2_r <= SW'(px1_r) + SW'(py1_r);
      rsq2_r <= SW'(px1_r) + SW'(py1_r) + SW'(pz1_r);
      dot2_r <= DW'(dx1_r) + DW'(dy1_r) + DW'(dz1_r);
      x2_r <= x1_r; y2_r <= y1_r; z2_r <= z1_r;
    end
  end

  // square root chains (range and horizontal range)
  logic [SW-1:0] rr_rem [RW+1];
  logic [RW-1:0] rr_root [RW+1];
  logic [SW-1:0] hr_rem [RW+1];
  logic [RW-1:0] hr_root [RW+1];
  assign rr_rem[0] = rsq2_r;
  assign rr_root[0] = '0;
  assign hr_rem[0] = hsq2_r;
  assign hr_root[0] = '0;
  // azimuth CORDIC runs alongside, fed from front stage
  logic signed [CW-1:0] ax [NI+1];
  logic signed [CW-1:0] ay [NI+1];
  logic signed [AW-1:0] aa [NI+1];
  always_comb begin
    if (x2_r < 0) begin
      ax[0] = -(CW'(x2_r) <<< 8);
      ay[0] = -(CW'(y2_r) <<< 8);
      aa[0] = (y2_r >= 0) ? $signed(c2sd_pkg::HalfTurn) : -$signed(c2sd_pkg::HalfTurn);
    end else begin
      ax[0] = CW'(x2_r) <<< 8;
      ay[0] = CW'(y2_r) <<< 8;
      aa[0] = '0;
    end
  end
  for (genvar i = 0; i < NI; i++) begin : g_az
    c2sd_cordic_cell u_cell (
      .clk(clk), .en(en), .step_i(5'(i)), .x_i(ax[i]), .y_i(ay[i]), .a_i(aa[i]),
      .x_r(ax[i+1]), .y_r(ay[i+1]), .a_r(aa[i+1]));
  end
  for (genvar i = 0; i < RW; i++) begin : g_sq
    c2sd_isqrt_cell u_rr (
      .clk(clk), .en(en), .step_i(5'(i)), .rem_i(rr_rem[i]), .root_i(rr_root[i]),
      .rem_r(rr_rem[i+1]), .root_r(rr_root[i+1]));
    c2sd_isqrt_cell u_hr (
      .clk(clk), .en(en), .step_i(5'(i)), .rem_i(hr_rem[i]), .root_i(hr_root[i]),
      .rem_r(hr_rem[i+1]), .root_r(hr_root[i+1]));
  end

  // side delay lines
  logic signed [23:0] zd_r [RW];
  logic signed [DW-1:0] dd_r [RW];
  logic is3_d_r [L2];
  logic [15:0] az_d_r [L2+QW-(3+NI)];
  always_ff @(posedge clk) begin
    if (en) begin
      zd_r[0] <= z2_r;
      dd_r[0] <= dot2_r;
      for (int k = 1; k < RW; k++) begin
        zd_r[k] <= zd_r[k-1];
        dd_r[k] <= dd_r[k-1];
      end
      is3_d_r[0] <= is3d_r;
      for (int k = 1; k < L2; k++) is3_d_r[k] <= is3_d_r[k-1];
    end
  end

  // azimuth result, delayed to output
  localparam int AZD = LT - (3 + NI);
  logic signed [AW-1:0] az_full;
  logic [15:0] az_val;
  logic xy0_az_r [NI];
  always_ff @(posedge clk) begin
    if (en) begin
      xy0_az_r[0] <= (x2_r == 0) && (y2_r == 0);
      for (int k = 1; k < NI; k++) xy0_az_r[k] <= xy0_az_r[k-1];
    end
  end
  assign az_full = (aa[NI] + AW'(256)) >>> 9;
  assign az_val = xy0_az_r[NI-1] ? 16'd0 : az_full[15:0];
  always_ff @(posedge clk) begin
    if (en) begin
      az_d_r[0] <= az_val;
      for (int k = 1; k < AZD; k++) az_d_r[k] <= az_d_r[k-1];
    end
  end

  // elevation CORDIC from roots
  logic signed [CW-1:0] ex [NI+1];
  logic signed [CW-1:0] ey [NI+1];
  logic signed [AW-1:0] ea [NI+1];
  logic [RW-1:0] rng_root, hr_root_f;
  logic signed [23:0] z_at_root;
  assign rng_root = rr_root[RW];
  assign hr_root_f = hr_root[RW];
  assign z_at_root = zd_r[RW-1];
  assign ex[0] = CW'({1'b0, hr_root_f}) <<< 8;
  assign ey[0] = CW'(z_at_root) <<< 8;
  assign ea[0] = '0;
  for (genvar i = 0; i < NI; i++) begin : g_el
    c2sd_cordic_cell u_cell (
      .clk(clk), .en(en), .step_i(5'(i)), .x_i(ex[i]), .y_i(ey[i]), .a_i(ea[i]),
      .x_r(ex[i+1]), .y_r(ey[i+1]), .a_r(ea[i+1]));
  end
  // side info for elevation stage
  logic [RW-1:0] rng_e_r [NI];
  logic signed [DW-1:0] dot_e_r [NI];
  logic hz_e_r [NI];
  logic signed [1:0] zs_e_r [NI];
  always_ff @(posedge clk) begin
    if (en) begin
      rng_e_r[0] <= rng_root;
      dot_e_r[0] <= dd_r[RW-1];
      hz_e_r[0] <= (hr_root_f == '0);
      zs_e_r[0] <= (z_at_root > 0) ? 2'sd1 : (z_at_root < 0) ? -2'sd1 : 2'sd0;
      for (int k = 1; k < NI; k++) begin
        rng_e_r[k] <= rng_e_r[k-1];
        dot_e_r[k] <= dot_e_r[k-1];
        hz_e_r[k] <= hz_e_r[k-1];
        zs_e_r[k] <= zs_e_r[k-1];
      end
    end
  end
  logic signed [AW-1:0] el_full;
  logic signed [15:0] el_val;
  logic is3_e;
  assign is3_e = is3_d_r[L2-1];
  always_comb begin
    el_full = (ea[NI] + AW'(256)) >>> 9;
    if (!is3_e) el_val = '0;
    else if (hz_e_r[NI-1]) el_val = 16'(zs_e_r[NI-1]) <<< 14;
    else if (el_full > AW'(16384)) el_val = 16'sd16384;
    else if (el_full < -AW'(16384)) el_val = -16'sd16384;
    else el_val = el_full[15:0];
  end

  // divider: |dot| + rng/2 over rng
  logic [RW-1:0] rng_e;
  logic signed [DW-1:0] dot_e;
  logic [DVW-1:0] num;
  assign rng_e = rng_e_r[NI-1];
  assign dot_e = dot_e_r[NI-1];
  assign num = DVW'(dot_e < 0 ? -dot_e : dot_e) + DVW'(rng_e >> 1);
  logic [DVW-1:0] dv_rem [QW+1];
  logic [QW-1:0] dv_q [QW+1];
  logic [RW-1:0] dv_den [QW];
  assign dv_rem[0] = num;
  assign dv_q[0] = '0;
  assign dv_den[0] = rng_e;
  logic [RW-1:0] den_r [QW];
  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= rng_e;
      for (int k = 1; k < QW; k++) den_r[k] <= den_r[k-1];
    end
  end
  for (genvar i = 0; i < QW; i++) begin : g_dv
    if (i > 0) begin : g_d
      assign dv_den[i] = den_r[i-1];
    end
    c2sd_div_cell u_cell (
      .clk(clk), .en(en), .step_i(5'(i)), .rem_i(dv_rem[i]), .den_i(dv_den[i]),
      .q_i(dv_q[i]), .rem_r(dv_rem[i+1]), .q_r(dv_q[i+1]));
  end
  // side info along divider; quotient overflow caught as num >> QW >= rng
  logic [15:0] el_d_r [QW];
  logic neg_d_r [QW];
  logic big_d_r [QW];
  always_ff @(posedge clk) begin
    if (en) begin
      el_d_r[0] <= el_val;
      neg_d_r[0] <= dot_e < 0;
      big_d_r[0] <= (num >> QW) >= DVW'(rng_e);
      for (int k = 1; k < QW; k++) begin
        el_d_r[k] <= el_d_r[k-1];
        neg_d_r[k] <= neg_d_r[k-1];
        big_d_r[k] <= big_d_r[k-1];
      end
    end
  end
  logic [RW-1:0] rng_f;
  logic hz_f_r [QW];
  always_ff @(posedge clk) begin
    if (en) begin
      hz_f_r[0] <= hz_e_r[NI-1] && is3_e;
      for (int k = 1; k < QW; k++) hz_f_r[k] <= hz_f_r[k-1];
    end
  end
  assign rng_f = den_r[QW-1];

  // output register
  logic [QW:0] qmag;
  logic signed [QW:0] rvs;
  logic signed [20:0] rv_val;
  always_comb begin
    qmag = big_d_r[QW-1] ? (QW+1)'(1048576) : {1'b0, dv_q[QW]};
    if (qmag > (QW+1)'(1048576)) qmag = (QW+1)'(1048576);
    rvs = neg_d_r[QW-1] ? -$signed(qmag) : $signed(qmag);
    if (rng_f == '0) rv_val = '0;
    else if (rvs > (QW+1)'(1048575)) rv_val = 21'sd1048575;
    else rv_val = rvs[20:0];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= v_r[LT-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_slant_range <= rng_f[RW-1] ? 24'hFFFFFF : rng_f[23:0];
      out_azimuth <= az_d_r[AZD-1];
      out_elevation <= el_d_r[QW-1];
      out_radial_velocity <= rv_val;
      out_zero_range <= (rng_f == '0) || hz_f_r[QW-1];
    end
  end
endmodule

// ===== rtl/c2sd_checker.sv =====
module c2sd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_ready,
  input logic out_zero_range,
  input logic [23:0] out_slant_range,
  input logic signed [20:0] out_radial_velocity,
  input logic signed [15:0] out_elevation
);
  a_zero_rv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_slant_range == 24'd0 |-> out_radial_velocity == 21'sd0 && out_zero_range)
    else $error("zero range with nonzero velocity");
  a_el_lim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_elevation <= 16'sd16384 && out_elevation >= -16'sd16384)
    else $error("elevation out of range");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slant_range))
    else $error("output dropped");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready && cfg_ready)
    else $error("stall without pending beat");
endmodule

bind cartesian_to_spherical_doppler_core c2sd_checker u_c2sd_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .cfg_ready(cfg_ready),
  .out_zero_range(out_zero_range), .out_slant_range(out_slant_range),
  .out_radial_velocity(out_radial_velocity), .out_elevation(out_elevation));

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint HalfTurn = 64'sd16777216;
  localparam longint QuarterOut = 64'sd16384;
  localparam longint RvMax = 64'sd1048575;
  localparam longint RvMin = -64'sd1048576;
  localparam int DrainCycles = 300;

  typedef struct {
    logic [23:0]        slant_range;
    logic signed [15:0] azimuth;
    logic signed [15:0] elevation;
    logic signed [20:0] radial_velocity;
    logic               zero_range;
  } polar_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [23:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [19:0] in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [23:0] out_slant_range;
  logic signed [15:0] out_azimuth, out_elevation;
  logic signed [20:0] out_radial_velocity;
  logic out_zero_range;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_three_dimensional = 1'b1;

  polar_t pending_polar[$];
  logic mode_3d = 1'b1;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_on = 1'b0;

  longint atan_steps[24] = '{
    4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
    20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1
  };

  always #1 clk = ~clk;

  cartesian_to_spherical_doppler_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y), .in_vel_z(in_vel_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_slant_range(out_slant_range), .out_azimuth(out_azimuth),
    .out_elevation(out_elevation), .out_radial_velocity(out_radial_velocity),
    .out_zero_range(out_zero_range),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_three_dimensional(cfg_three_dimensional)
  );

  function automatic longint int_root(longint unsigned n);
    longint unsigned res = 0, b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint vector_angle(longint vx, longint vy);
    longint acc = 0;
    longint dx, dy;
    if (vx < 0) begin
      acc = (vy >= 0) ? HalfTurn : -HalfTurn;
      vx = -vx;
      vy = -vy;
    end
    for (int i = 0; i < c2sd_pkg::AngleIterations && i < 24; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx = vx + dx; vy = vy - dy; acc = acc + atan_steps[i];
      end else begin
        vx = vx - dx; vy = vy + dy; acc = acc - atan_steps[i];
      end
    end
    return (acc + 256) >>> 9;
  endfunction

  function automatic polar_t to_polar(logic signed [23:0] px, logic signed [23:0] py,
                                      logic signed [23:0] pz, logic signed [19:0] qx,
                                      logic signed [19:0] qy, logic signed [19:0] qz,
                                      logic is3d);
    polar_t r;
    longint x = px, y = py, z = is3d ? longint'(pz) : 0;
    longint vx = qx, vy = qy, vz = is3d ? longint'(qz) : 0;
    longint hsq, rng, hr, az, el, rv, dot;
    longint unsigned mag, q;
    logic zero = 1'b0;
    hsq = x * x + y * y;
    rng = int_root(hsq + z * z);
    hr = int_root(hsq);
    dot = x * vx + y * vy + z * vz;
    az = (x != 0 || y != 0) ? vector_angle(x * 256, y * 256) : 0;
    el = 0;
    if (is3d) begin
      if (hr == 0) begin
        zero = 1'b1;
        el = (z > 0) ? QuarterOut : (z < 0) ? -QuarterOut : 0;
      end else begin
        el = vector_angle(hr * 256, z * 256);
        if (el > QuarterOut) el = QuarterOut;
        if (el < -QuarterOut) el = -QuarterOut;
      end
    end
    rv = 0;
    if (rng == 0) begin
      zero = 1'b1;
    end else begin
      mag = (dot < 0) ? -dot : dot;
      q = (mag + rng / 2) / rng;
      if (q > RvMax + 1) q = RvMax + 1;
      rv = (dot < 0) ? -longint'(q) : longint'(q);
      if (rv > RvMax) rv = RvMax;
      if (rv < RvMin) rv = RvMin;
    end
    if (rng > 16777215) rng = 16777215;
    r.slant_range = rng[23:0];
    r.azimuth = az[15:0];
    r.elevation = el[15:0];
    r.radial_velocity = rv[20:0];
    r.zero_range = zero;
    return r;
  endfunction

  // result checker and receiver idling
  always @(posedge clk) begin
    polar_t e;
    if (out_valid && out_ready) begin
      if (pending_polar.size() == 0) begin
        $display("%0t: unexpected result beat range=%0d", $time, out_slant_range);
        errors++;
      end else begin
        e = pending_polar.pop_front();
        if (out_slant_range !== e.slant_range) begin
          $display("%0t: slant_range exp %0d got %0d", $time, e.slant_range,
                   out_slant_range);
          errors++;
        end
        if (out_azimuth !== e.azimuth) begin
          $display("%0t: azimuth exp %0d got %0d", $time, e.azimuth, out_azimuth);
          errors++;
        end
        if (out_elevation !== e.elevation) begin
          $display("%0t: elevation exp %0d got %0d", $time, e.elevation, out_elevation);
          errors++;
        end
        if (out_radial_velocity !== e.radial_velocity) begin
          $display("%0t: radial_velocity exp %0d got %0d", $time, e.radial_velocity,
                   out_radial_velocity);
          errors++;
        end
        if (out_zero_range !== e.zero_range) begin
          $display("%0t: zero_range exp %0b got %0b", $time, e.zero_range,
                   out_zero_range);
          errors++;
        end
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_on) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_target(logic signed [23:0] x, logic signed [23:0] y,
                             logic signed [23:0] z, logic signed [19:0] vx,
                             logic signed [19:0] vy, logic signed [19:0] vz);
    int gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= x; in_pos_y <= y; in_pos_z <= z;
    in_vel_x <= vx; in_vel_y <= vy; in_vel_z <= vz;
    do @(posedge clk); while (!in_ready);
    pending_polar.push_back(to_polar(x, y, z, vx, vy, vz, mode_3d));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_polar.size() != 0) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_three_dimensional <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_3d = m;
  endtask

  function automatic longint pick_value(int w);
    longint lim = 64'sd1 << (w - 1);
    case ($urandom_range(4))
      0: return longint'($urandom_range(64)) - 32;
      1: return longint'($urandom_range(65535)) - 32768;
      2: case ($urandom_range(4))
           0: return lim - 1;
           1: return -lim;
           2: return 0;
           3: return -1;
           default: return 1;
         endcase
      default: return longint'({$urandom, $urandom}) % lim;
    endcase
  endfunction

  task automatic send_random(int n);
    longint x, y, z, vx, vy, vz;
    repeat (n) begin
      x = pick_value(24); y = pick_value(24); z = pick_value(24);
      vx = pick_value(20); vy = pick_value(20); vz = pick_value(20);
      if ($urandom_range(9) == 0) x = 0;
      if ($urandom_range(9) == 0) y = 0;
      if ($urandom_range(9) == 0) z = 0;
      send_target(x[23:0], y[23:0], z[23:0], vx[19:0], vy[19:0], vz[19:0]);
    end
  endtask

  task automatic send_corners();
    send_target(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 20'sh7ffff, 20'sh7ffff, 20'sh7ffff);
    send_target(-24'sh800000, -24'sh800000, -24'sh800000, -20'sh80000, -20'sh80000,
                -20'sh80000);
    send_target(24'sh7fffff, -24'sh800000, 24'sh7fffff, -20'sh80000, 20'sh7ffff,
                -20'sh80000);
    send_target('0, '0, '0, 20'sh7ffff, -20'sh80000, 20'sh12345);
    send_target('0, '0, 24'sd1000, 20'sd5, 20'sd5, 20'sd256);
    send_target('0, '0, -24'sd1000, 20'sd5, 20'sd5, -20'sd256);
    send_target(-24'sd500, '0, '0, 20'sd100, '0, '0);
    send_target(-24'sd500, -24'sd1, '0, '0, 20'sd100, '0);
    send_target('0, 24'sd700, 24'sd3, '0, -20'sd9, '0);
    send_target('0, -24'sd700, -24'sd3, '0, 20'sd9, '0);
    send_target(24'sd1, 24'sd1, 24'sd1, -20'sd1, -20'sd1, -20'sd1);
    send_target(-24'sd1, 24'sd1, '0, 20'sd1, '0, '0);
    send_target(24'sd1, '0, '0, 20'sd1, '0, '0);
    send_target(24'sd3, 24'sd4, '0, 20'sd1, 20'sd1, '0);
    send_target(24'sh555555, -24'sh2aaaab, 24'sh0f0f0f, 20'sh55555, -20'sh2aaab,
                20'sh0f0f0);
  endtask

  task automatic test_directed_3d();
    write_mode(1'b1);
    send_corners();
  endtask

  task automatic test_directed_2d();
    write_mode(1'b0);
    send_corners();
  endtask

  task automatic test_random_modes();
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 19 : (p == 1) ? 59 : 0;
      recv_idle_pct = (p == 0) ? 59 : (p == 1) ? 19 : 0;
      write_mode(1'b1);
      send_random(250);
      write_mode(1'b0);
      send_random(150);
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
  endtask

  task automatic test_backpressure();
    write_mode(1'b1);
    fork
      begin
        hold_on <= 1'b1;
        repeat (400) @(posedge clk);
        hold_on <= 1'b0;
      end
      send_random(200);
    join
  endtask

  task automatic test_pause();
    send_random(20);
    wait_drained();
    send_random(20);
    write_mode(1'b0);
    send_random(20);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_3d();
    test_directed_2d();
    test_random_modes();
    test_backpressure();
    test_pause();
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && pending_polar.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
